/* hdl/gtcf_pkg.sv */
// gtcf_pkg: types, constants and small functions of the gated tilt filter
// used by gtcf_cordic, gated_tilt_complementary_filter and the testbench; depends on nothing
`default_nettype none

package gtcf_pkg;

    // operand widths
    localparam int AX_W  = 17;   // offset-corrected acceleration / rate
    localparam int EST_W = 16;   // angle estimates, 1/8192 rad
    localparam int ACC_W = 52;   // mac accumulator
    localparam int MA_W  = 30;   // mac operand a
    localparam int MB_W  = 22;   // mac operand b
    localparam int Q_W   = 20;   // quotient estimate of the divide by 1000
    localparam int SQ_W  = 22;   // pre-saturation width
    localparam int CX_W  = 36;   // cordic x/y
    localparam int CZ_W  = 21;   // cordic angle, 1/65536 rad

    // gate on squared magnitude, units (1/256 m/s^2)^2
    localparam logic signed [ACC_W-1:0] MAG_LOW  = ACC_W'(64 * 65536);
    localparam logic signed [ACC_W-1:0] MAG_HIGH = ACC_W'(121 * 65536);

    // blend weights in thousandths, bias carries the rounding half and an offset
    // of 1000*DIV_K that keeps the numerator positive for the divide
    localparam logic signed [MB_W-1:0]  W_ANG      = MB_W'(250);
    localparam logic signed [MB_W-1:0]  W_OLD      = MB_W'(750);
    localparam logic signed [MB_W-1:0]  NEG_1000   = -MB_W'(1000);
    localparam logic signed [MB_W-1:0]  RECIP_1000 = MB_W'(1073741); // floor(2^30/1000)
    localparam int                      RECIP_SH   = 30;
    localparam logic signed [SQ_W-1:0]  DIV_K      = SQ_W'(262144);
    localparam logic signed [ACC_W-1:0] BLEND_BIAS = ACC_W'(262144500);
    localparam logic signed [ACC_W-1:0] DIV_ONE    = ACC_W'(1000);

    localparam logic signed [CZ_W-1:0]  PI_FINE = CZ_W'(205887);

    // register map, index = paddr / 4
    localparam logic [2:0] REG_ACCEL_X_OFFSET = 3'd0;
    localparam logic [2:0] REG_ACCEL_Y_OFFSET = 3'd1;
    localparam logic [2:0] REG_ACCEL_Z_OFFSET = 3'd2;
    localparam logic [2:0] REG_RATE_Y_OFFSET  = 3'd3;
    localparam logic [2:0] REG_RATE_Z_OFFSET  = 3'd4;
    localparam logic [2:0] REG_TRIM_X         = 3'd5;
    localparam logic [2:0] REG_TRIM_Y         = 3'd6;

    typedef enum logic [1:0] {
        MODE_ARMED   = 2'd0,
        MODE_ACTIVE  = 2'd1,
        MODE_DRINK   = 2'd2,
        MODE_LOADING = 2'd3
    } mode_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SEED_GO,
        ST_SEED_WAIT,
        ST_MAG0,
        ST_MAG1,
        ST_MAG2,
        ST_MAG3,
        ST_MAG4,
        ST_ANG_GO,
        ST_ANG_WAIT,
        ST_BL0,
        ST_BL1,
        ST_BL2,
        ST_DQ,
        ST_DR,
        ST_FIX,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cordic_status_t;

    // atan(2^-i) in 1/65536 rad
    function automatic logic [15:0] atan_fine(input logic [4:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30386;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [SQ_W-1:0] v);
        logic signed [15:0] r;
        if (v > SQ_W'(32767)) begin
            r = 16'sh7fff;
        end
        else if (v < -SQ_W'(32768)) begin
            r = 16'sh8000;
        end
        else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/gtcf_ifs.sv */
// gtcf_sample_if and gtcf_command_if: valid/ready channels of the tilt filter
// no dependencies
`default_nettype none

interface gtcf_sample_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] accel_x;
    logic signed [14:0] accel_y;
    logic signed [14:0] accel_z;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic               button_pressed;
    logic [9:0]         elapsed_ms;

    modport source (
        output valid, accel_x, accel_y, accel_z, rate_y, rate_z, button_pressed, elapsed_ms,
        input  ready
    );
    modport sink (
        input  valid, accel_x, accel_y, accel_z, rate_y, rate_z, button_pressed, elapsed_ms,
        output ready
    );
endinterface

interface gtcf_command_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] x_angle_cmd;
    logic signed [15:0] y_angle_cmd;
    logic [1:0]         mode;

    modport source (
        output valid, x_angle_cmd, y_angle_cmd, mode,
        input  ready
    );
    modport sink (
        input  valid, x_angle_cmd, y_angle_cmd, mode,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/gated_tilt_complementary_filter.sv */
// Gated tilt complementary filter. Takes one IMU sample per beat, adds the calibration offsets,
// gates a cordic atan2 tilt per axis on the squared accel magnitude, blends it 1/4 : 3/4 with
// the gyro-propagated estimate and drives two saturated servo commands from a button-driven
// armed/active/drink mode machine. One sample is in work at a time and sample.ready is high
// only while the block is idle. An accepted sample runs through the magnitude states, then per
// axis the angle step (a cordic run only if the axis is gated on), blend, divide and fix, and
// waits in ST_OUT for a free output register; sample.ready rises again at the edge that raises
// command.valid. The cordic unit does one micro-rotation a cycle and runs once per gated axis,
// and a single shared multiply-accumulate unit does the magnitudes, the blend and the divide
// by 1000 in turn. The first sample after reset only seeds the estimates, with one cordic run
// per axis, and gives no command beat. A finished command waits in an output register, so the
// next sample can be taken while it is not yet consumed.
// depends on gtcf_pkg, gtcf_ifs (gtcf_sample_if, gtcf_command_if) and gtcf_cordic
`default_nettype none

module gated_tilt_complementary_filter
    import gtcf_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    gtcf_sample_if.sink      sample,
    gtcf_command_if.source   command
);

    // configuration
    logic signed [12:0] accel_x_offset_reg;
    logic signed [12:0] accel_y_offset_reg;
    logic signed [12:0] accel_z_offset_reg;
    logic signed [13:0] rate_y_offset_reg;
    logic signed [13:0] rate_z_offset_reg;
    logic signed [14:0] trim_x_reg;
    logic signed [14:0] trim_y_reg;
    logic [2:0]         reg_idx;
    logic               cfg_write;

    // control
    state_t state_reg;
    state_t state_next;
    mode_t  mode_reg;
    logic   axis_reg;
    logic   out_valid_reg;

    // sample and working registers
    logic signed [AX_W-1:0]  ax_reg;
    logic signed [AX_W-1:0]  ay_reg;
    logic signed [AX_W-1:0]  az_reg;
    logic signed [AX_W-1:0]  gy_reg;
    logic signed [AX_W-1:0]  gz_reg;
    logic [11:0]             ms3_reg;
    logic                    btn_reg;
    logic                    gate_x_reg;
    logic                    gate_y_reg;
    logic signed [EST_W-1:0] est_x_reg;
    logic signed [EST_W-1:0] est_y_reg;
    logic signed [EST_W-1:0] ang_reg;
    logic [Q_W-1:0]          q0_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [15:0]      out_x_reg;
    logic signed [15:0]      out_y_reg;
    logic [1:0]              out_mode_reg;

    // mac unit controls
    logic                    mac_en;
    logic                    mac_keep;
    logic signed [MA_W-1:0]  mac_a;
    logic signed [MB_W-1:0]  mac_b;
    logic signed [ACC_W-1:0] mac_add;
    logic signed [ACC_W-1:0] mac_prod;

    logic                    sample_accept;
    logic                    out_load;
    logic                    cordic_start;
    cordic_status_t          cordic_status;
    logic signed [AX_W-1:0]  cordic_y;
    logic signed [AX_W-1:0]  cordic_x;
    logic signed [EST_W-1:0] cordic_angle;

    logic                    axis_gate;
    logic signed [EST_W-1:0] est_sel;
    logic signed [AX_W-1:0]  g_sel;
    logic                    round_up;
    logic signed [SQ_W-1:0]  q_full;
    logic signed [EST_W-1:0] est_new;
    logic signed [SQ_W-1:0]  sum_x;
    logic signed [SQ_W-1:0]  sum_y_neg;
    logic signed [15:0]      cmd_x;
    logic signed [15:0]      cmd_y;
    mode_t                   mode_after;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            accel_x_offset_reg <= '0;
            accel_y_offset_reg <= '0;
            accel_z_offset_reg <= '0;
            rate_y_offset_reg  <= '0;
            rate_z_offset_reg  <= '0;
            trim_x_reg         <= '0;
            trim_y_reg         <= '0;
        end
        else if (cfg_write) begin
            case (reg_idx)
                REG_ACCEL_X_OFFSET: accel_x_offset_reg <= pwdata[12:0];
                REG_ACCEL_Y_OFFSET: accel_y_offset_reg <= pwdata[12:0];
                REG_ACCEL_Z_OFFSET: accel_z_offset_reg <= pwdata[12:0];
                REG_RATE_Y_OFFSET:  rate_y_offset_reg  <= pwdata[13:0];
                REG_RATE_Z_OFFSET:  rate_z_offset_reg  <= pwdata[13:0];
                REG_TRIM_X:         trim_x_reg         <= pwdata[14:0];
                REG_TRIM_Y:         trim_y_reg         <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ACCEL_X_OFFSET: prdata = 32'(accel_x_offset_reg);
            REG_ACCEL_Y_OFFSET: prdata = 32'(accel_y_offset_reg);
            REG_ACCEL_Z_OFFSET: prdata = 32'(accel_z_offset_reg);
            REG_RATE_Y_OFFSET:  prdata = 32'(rate_y_offset_reg);
            REG_RATE_Z_OFFSET:  prdata = 32'(rate_z_offset_reg);
            REG_TRIM_X:         prdata = 32'(trim_x_reg);
            REG_TRIM_Y:         prdata = 32'(trim_y_reg);
            default:            prdata = '0;
        endcase
    end

    // ---------------- shared units ----------------
    assign mac_prod = mac_a * mac_b;
    assign acc_next = (mac_keep ? acc_reg : '0) + mac_prod + mac_add;

    assign cordic_y = axis_reg ? az_reg : ay_reg;
    assign cordic_x = -ax_reg;

    gtcf_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cordic_start),
        .y_in   (cordic_y),
        .x_in   (cordic_x),
        .status (cordic_status),
        .angle  (cordic_angle)
    );

    // ---------------- per-axis selection ----------------
    assign axis_gate = axis_reg ? gate_y_reg : gate_x_reg;
    assign est_sel   = axis_reg ? est_y_reg : est_x_reg;
    assign g_sel     = axis_reg ? gy_reg : gz_reg;

    // remainder in [0, 2000) after the reciprocal step, one correction
    assign round_up = acc_reg >= DIV_ONE;
    assign q_full   = $signed({2'b00, q0_reg}) + $signed({21'd0, round_up}) - DIV_K;
    assign est_new  = sat16(q_full);

    // ---------------- commands and mode ----------------
    assign sum_x     = SQ_W'(est_x_reg) + SQ_W'(trim_x_reg);
    assign sum_y_neg = -(SQ_W'(est_y_reg) + SQ_W'(trim_y_reg));

    always_comb begin
        case (mode_reg)
            MODE_ARMED: begin
                cmd_x      = 16'(trim_x_reg);
                cmd_y      = sat16(-SQ_W'(trim_y_reg));
                mode_after = btn_reg ? MODE_ACTIVE : MODE_ARMED;
            end
            MODE_ACTIVE: begin
                cmd_x      = sat16(sum_x);
                cmd_y      = sat16(sum_y_neg);
                mode_after = btn_reg ? MODE_DRINK : MODE_ACTIVE;
            end
            default: begin
                cmd_x      = 16'(trim_x_reg);
                cmd_y      = sat16(sum_y_neg);
                mode_after = btn_reg ? MODE_DRINK : MODE_ACTIVE;
            end
        endcase
    end

    // ---------------- sequencer: next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (sample_accept) begin
                    state_next = (mode_reg == MODE_LOADING) ? ST_SEED_GO : ST_MAG0;
                end
            end
            ST_SEED_GO:   state_next = ST_SEED_WAIT;
            ST_SEED_WAIT: begin
                if (cordic_status.done) begin
                    state_next = axis_reg ? ST_IDLE : ST_SEED_GO;
                end
            end
            ST_MAG0:      state_next = ST_MAG1;
            ST_MAG1:      state_next = ST_MAG2;
            ST_MAG2:      state_next = ST_MAG3;
            ST_MAG3:      state_next = ST_MAG4;
            ST_MAG4:      state_next = ST_ANG_GO;
            ST_ANG_GO:    state_next = axis_gate ? ST_ANG_WAIT : ST_BL0;
            ST_ANG_WAIT: begin
                if (cordic_status.done) begin
                    state_next = ST_BL0;
                end
            end
            ST_BL0:       state_next = ST_BL1;
            ST_BL1:       state_next = ST_BL2;
            ST_BL2:       state_next = ST_DQ;
            ST_DQ:        state_next = ST_DR;
            ST_DR:        state_next = ST_FIX;
            ST_FIX:       state_next = axis_reg ? ST_OUT : ST_ANG_GO;
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    assign sample.ready  = (state_reg == ST_IDLE);
    assign sample_accept = sample.valid && sample.ready;
    assign out_load      = (state_reg == ST_OUT) && (!out_valid_reg || command.ready);

    always_comb begin
        mac_en       = 1'b0;
        mac_keep     = 1'b0;
        mac_a        = '0;
        mac_b        = '0;
        mac_add      = '0;
        cordic_start = 1'b0;
        case (state_reg)
            ST_SEED_GO: cordic_start = 1'b1;
            ST_MAG0: begin
                mac_en = 1'b1;
                mac_a  = MA_W'(ax_reg);
                mac_b  = MB_W'(ax_reg);
            end
            ST_MAG1: begin
                mac_en   = 1'b1;
                mac_keep = 1'b1;
                mac_a    = MA_W'(ay_reg);
                mac_b    = MB_W'(ay_reg);
            end
            ST_MAG2: begin
                mac_en = 1'b1;
                mac_a  = MA_W'(az_reg);
                mac_b  = MB_W'(az_reg);
            end
            ST_MAG3: begin
                mac_en   = 1'b1;
                mac_keep = 1'b1;
                mac_a    = MA_W'(ax_reg);
                mac_b    = MB_W'(ax_reg);
            end
            ST_ANG_GO: cordic_start = axis_gate;
            ST_BL0: begin
                mac_en  = 1'b1;
                mac_a   = MA_W'(ang_reg);
                mac_b   = W_ANG;
                mac_add = BLEND_BIAS;
            end
            ST_BL1: begin
                mac_en   = 1'b1;
                mac_keep = 1'b1;
                mac_a    = MA_W'(est_sel);
                mac_b    = W_OLD;
            end
            ST_BL2: begin
                // gyro step: -3 * g * ms
                mac_en   = 1'b1;
                mac_keep = 1'b1;
                mac_a    = MA_W'(g_sel);
                mac_b    = -$signed({10'd0, ms3_reg});
            end
            ST_DQ: begin
                // numerator is positive and below 2^29 here
                mac_a = acc_reg[MA_W-1:0];
                mac_b = RECIP_1000;
            end
            ST_DR: begin
                mac_en   = 1'b1;
                mac_keep = 1'b1;
                mac_a    = $signed({{(MA_W - Q_W){1'b0}}, q0_reg});
                mac_b    = NEG_1000;
            end
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_LOADING;
            axis_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            if (sample_accept) begin
                axis_reg <= 1'b0;
            end
            else if ((state_reg == ST_SEED_WAIT && cordic_status.done) || state_reg == ST_FIX) begin
                axis_reg <= 1'b1;
            end
            if (state_reg == ST_SEED_WAIT && cordic_status.done && axis_reg) begin
                mode_reg <= MODE_ARMED;
            end
            else if (out_load) begin
                mode_reg <= mode_after;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end
            else if (command.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk) begin
        if (sample_accept) begin
            // seeding uses the raw accelerations
            if (mode_reg == MODE_LOADING) begin
                ax_reg <= AX_W'(sample.accel_x);
                ay_reg <= AX_W'(sample.accel_y);
                az_reg <= AX_W'(sample.accel_z);
            end
            else begin
                ax_reg <= AX_W'(sample.accel_x) + AX_W'(accel_x_offset_reg);
                ay_reg <= AX_W'(sample.accel_y) + AX_W'(accel_y_offset_reg);
                az_reg <= AX_W'(sample.accel_z) + AX_W'(accel_z_offset_reg);
            end
            gy_reg  <= AX_W'(sample.rate_y) + AX_W'(rate_y_offset_reg);
            gz_reg  <= AX_W'(sample.rate_z) + AX_W'(rate_z_offset_reg);
            ms3_reg <= {2'b00, sample.elapsed_ms} + {1'b0, sample.elapsed_ms, 1'b0};
            btn_reg <= sample.button_pressed;
        end

        if (mac_en) begin
            acc_reg <= acc_next;
        end
        if (state_reg == ST_DQ) begin
            q0_reg <= mac_prod[RECIP_SH +: Q_W];
        end

        if (state_reg == ST_MAG2) begin
            gate_x_reg <= (acc_reg > MAG_LOW) && (acc_reg < MAG_HIGH);
        end
        if (state_reg == ST_MAG4) begin
            gate_y_reg <= (acc_reg > MAG_LOW) && (acc_reg < MAG_HIGH);
        end

        if (state_reg == ST_ANG_GO && !axis_gate) begin
            ang_reg <= est_sel;
        end
        else if (state_reg == ST_ANG_WAIT && cordic_status.done) begin
            ang_reg <= cordic_angle;
        end

        if (state_reg == ST_SEED_WAIT && cordic_status.done) begin
            if (axis_reg) begin
                est_y_reg <= cordic_angle;
            end
            else begin
                est_x_reg <= cordic_angle;
            end
        end
        else if (state_reg == ST_FIX) begin
            if (axis_reg) begin
                est_y_reg <= est_new;
            end
            else begin
                est_x_reg <= est_new;
            end
        end

        if (out_load) begin
            out_x_reg    <= cmd_x;
            out_y_reg    <= cmd_y;
            out_mode_reg <= mode_after;
        end
    end

    assign command.valid       = out_valid_reg;
    assign command.x_angle_cmd = out_x_reg;
    assign command.y_angle_cmd = out_y_reg;
    assign command.mode        = out_mode_reg;

    // ---------------- assertions ----------------
    a_cordic_start_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        cordic_start |-> !cordic_status.busy
    ) else $error("cordic restarted while busy");

    a_div_remainder: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIX) |-> (acc_reg >= 0) && (acc_reg < 2 * DIV_ONE)
    ) else $error("divide remainder out of range");

    a_out_loaded: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_load |=> command.valid && (state_reg == ST_IDLE)
    ) else $error("command beat not presented after result");

    a_no_loading_beat: assert property (
        @(posedge clk) disable iff (!rst_n)
        command.valid |-> (command.mode != MODE_LOADING) && (mode_reg != MODE_LOADING)
    ) else $error("command beat while still loading");

endmodule

`default_nettype wire

/* hdl/gtcf_cordic.sv */
// gtcf_cordic: iterative cordic atan2 in vectoring mode, one micro-rotation a cycle
// depends on gtcf_pkg
`default_nettype none

module gtcf_cordic
    import gtcf_pkg::*;
#(
    parameter int STEPS = 16
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [AX_W-1:0] y_in,
    input  wire logic signed [AX_W-1:0] x_in,
    output cordic_status_t          status,
    output logic signed [EST_W-1:0] angle
);

    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic signed [CX_W-1:0] x_reg;
    logic signed [CX_W-1:0] y_reg;
    logic signed [CZ_W-1:0] z_reg;

    logic signed [CX_W-1:0] x_load;
    logic signed [CX_W-1:0] y_load;
    logic signed [CX_W-1:0] x_sh;
    logic signed [CX_W-1:0] y_sh;
    logic signed [CZ_W-1:0] z_step;
    logic signed [CZ_W-1:0] z_round;

    assign x_load  = CX_W'(x_in) <<< 16;
    assign y_load  = CX_W'(y_in) <<< 16;
    assign x_sh    = x_reg >>> cnt_reg;
    assign y_sh    = y_reg >>> cnt_reg;
    assign z_step  = CZ_W'(atan_fine(5'(cnt_reg)));
    assign z_round = z_reg + CZ_W'(4);
    assign angle   = EST_W'(z_round >>> 3);

    assign status.busy = busy_reg;
    assign status.done = done_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg) begin
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            // left half plane: turn by pi first
            if (x_in < 0) begin
                x_reg <= -x_load;
                y_reg <= -y_load;
                z_reg <= (y_in >= 0) ? PI_FINE : -PI_FINE;
            end
            else begin
                x_reg <= x_load;
                y_reg <= y_load;
                z_reg <= '0;
            end
        end
        else if (busy_reg) begin
            if (y_reg >= 0) begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + z_step;
            end
            else begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - z_step;
            end
        end
    end

endmodule

`default_nettype wire

/* test/tb_gated_tilt_complementary_filter.sv */
// testbench for gated_tilt_complementary_filter: drives imu samples and apb register writes,
// predicts every servo command beat and checks it; depends on gtcf_pkg, gtcf_ifs and gated_tilt_complementary_filter
`timescale 1ns / 100ps

module tb_gated_tilt_complementary_filter;
    import gtcf_pkg::*;

    localparam int STEPS = 16;
    localparam int DRAIN = 80;                 // cycles past the last beat before a register write
    localparam longint HALF_TURN = 205887;     // pi in 1/65536 rad
    localparam logic [2:0] REG_NONE = 3'd7;    // beyond the register map
    localparam int REG_BITS [0:6] = '{13, 13, 13, 14, 14, 15, 15};
    localparam longint ATAN_STEP [0:23] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0
    };

    typedef struct packed {
        logic signed [14:0] accel_x;
        logic signed [14:0] accel_y;
        logic signed [14:0] accel_z;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic               button_pressed;
        logic [9:0]         elapsed_ms;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] x_angle_cmd;
        logic signed [15:0] y_angle_cmd;
        logic [1:0]         mode;
    } command_t;

    class tilt_checker;
        int       reg_val [0:6];
        int       est_x;
        int       est_y;
        mode_t    run_state;
        command_t cmd_due [$];
        int       mismatches;

        function new();
            foreach (reg_val[i]) reg_val[i] = 0;
            est_x = 0;
            est_y = 0;
            run_state = MODE_LOADING;
            mismatches = 0;
        endfunction

        function int pending();
            return cmd_due.size();
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            int w;
            logic [31:0] t;
            if (idx > REG_TRIM_Y) return;
            w = REG_BITS[idx];
            t = val << (32 - w);
            reg_val[idx] = $signed(t) >>> (32 - w);
        endfunction

        function int clamp16(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return int'(v);
        endfunction

        function longint div_floor(longint n, longint d);
            longint q;
            q = n / d;
            if ((n % d != 0) && (n < 0)) q = q - 1;
            return q;
        endfunction

        // vectoring cordic, 1/65536 rad inside, rounded half up to 1/8192 rad
        function int tilt_angle(longint yv, longint xv);
            longint xs, ys, z, xn, yn;
            xs = xv * 65536;
            ys = yv * 65536;
            z = 0;
            if (xs < 0) begin
                z = (ys >= 0) ? HALF_TURN : -HALF_TURN;
                xs = -xs;
                ys = -ys;
            end
            for (int i = 0; i < STEPS; i++) begin
                if (ys >= 0) begin
                    xn = xs + (ys >>> i);
                    yn = ys - (xs >>> i);
                    z += ATAN_STEP[i];
                end
                else begin
                    xn = xs - (ys >>> i);
                    yn = ys + (xs >>> i);
                    z -= ATAN_STEP[i];
                end
                xs = xn;
                ys = yn;
            end
            return int'((z + 4) >>> 3);
        endfunction

        function int blend_est(int ang, int old, longint g, longint ms);
            return clamp16(div_floor(250 * longint'(ang) + 750 * longint'(old) - 3 * g * ms
                                     + 500, 1000));
        endfunction

        function void take_sample(sample_t s);
            longint rx, ry, rz, gy, gz, ms, ax, ay, az, magx, magy;
            int angx, angy, cx, cy;
            command_t c;
            rx = longint'($signed(s.accel_x));
            ry = longint'($signed(s.accel_y));
            rz = longint'($signed(s.accel_z));
            gy = longint'($signed(s.rate_y)) + reg_val[REG_RATE_Y_OFFSET];
            gz = longint'($signed(s.rate_z)) + reg_val[REG_RATE_Z_OFFSET];
            ms = longint'(s.elapsed_ms);
            // first sample after reset seeds from raw accel, no beat
            if (run_state == MODE_LOADING) begin
                est_x = tilt_angle(ry, -rx);
                est_y = tilt_angle(rz, -rx);
                run_state = MODE_ARMED;
                return;
            end
            ax = rx + reg_val[REG_ACCEL_X_OFFSET];
            ay = ry + reg_val[REG_ACCEL_Y_OFFSET];
            az = rz + reg_val[REG_ACCEL_Z_OFFSET];
            magx = ax * ax + ay * ay;
            magy = az * az + ax * ax;
            angx = (magx > 64 * 65536 && magx < 121 * 65536) ? tilt_angle(ay, -ax) : est_x;
            angy = (magy > 64 * 65536 && magy < 121 * 65536) ? tilt_angle(az, -ax) : est_y;
            est_x = blend_est(angx, est_x, gz, ms);
            est_y = blend_est(angy, est_y, gy, ms);
            case (run_state)
                MODE_ARMED: begin
                    cx = clamp16(reg_val[REG_TRIM_X]);
                    cy = clamp16(-longint'(reg_val[REG_TRIM_Y]));
                    if (s.button_pressed) run_state = MODE_ACTIVE;
                end
                MODE_ACTIVE: begin
                    cx = clamp16(longint'(est_x) + reg_val[REG_TRIM_X]);
                    cy = clamp16(-(longint'(est_y) + reg_val[REG_TRIM_Y]));
                    if (s.button_pressed) run_state = MODE_DRINK;
                end
                default: begin
                    cx = clamp16(reg_val[REG_TRIM_X]);
                    cy = clamp16(-(longint'(est_y) + reg_val[REG_TRIM_Y]));
                    if (!s.button_pressed) run_state = MODE_ACTIVE;
                end
            endcase
            c.x_angle_cmd = 16'(cx);
            c.y_angle_cmd = 16'(cy);
            c.mode = run_state;
            cmd_due.push_back(c);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%s", msg);
        endfunction

        function void check_command(command_t got);
            command_t want;
            if (cmd_due.size() == 0) begin
                flag($sformatf("unexpected command beat: x=%0d y=%0d mode=%0d",
                               got.x_angle_cmd, got.y_angle_cmd, got.mode));
                return;
            end
            want = cmd_due.pop_front();
            if (got !== want)
                flag($sformatf("command mismatch: expected x=%0d y=%0d mode=%0d, got x=%0d y=%0d mode=%0d",
                               want.x_angle_cmd, want.y_angle_cmd, want.mode,
                               got.x_angle_cmd, got.y_angle_cmd, got.mode));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    wire  [31:0] prdata;
    wire         pready;

    gtcf_sample_if  sample_bus ();
    gtcf_command_if command_bus ();

    tilt_checker chk;
    bit quiet;
    bit btn_level;
    int gap_pct;
    int stall_pct;

    gated_tilt_complementary_filter #(
        .CORDIC_STEPS (STEPS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (sample_bus),
        .command (command_bus)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // receiver side: ready with random stall bursts
    initial begin
        command_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                command_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            command_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && command_bus.valid && command_bus.ready)
            chk.check_command({command_bus.x_angle_cmd, command_bus.y_angle_cmd,
                               command_bus.mode});
    end

    function automatic sample_t mk(int ax, int ay, int az, int gy, int gz, bit btn, int ms);
        sample_t s;
        s.accel_x = 15'(ax);
        s.accel_y = 15'(ay);
        s.accel_z = 15'(az);
        s.rate_y = 16'(gy);
        s.rate_z = 16'(gz);
        s.button_pressed = btn;
        s.elapsed_ms = 10'(ms);
        return s;
    endfunction

    // mostly gravity-sized vectors after offset correction, rest raw noise
    function automatic sample_t rand_sample();
        sample_t s;
        int ax, ay, az;
        real rad;
        if ($urandom_range(0, 99) < 20) begin
            s.accel_x = 15'($urandom);
            s.accel_y = 15'($urandom);
            s.accel_z = 15'($urandom);
            s.rate_y = 16'($urandom);
            s.rate_z = 16'($urandom);
            s.button_pressed = 1'($urandom);
            s.elapsed_ms = 10'($urandom);
            return s;
        end
        ax = int'($urandom_range(0, 4000)) - 2000;
        rad = 2040.0 + 785.0 * $urandom_range(0, 1000) / 1000.0;
        ay = int'($sqrt(rad * rad - real'(ax * ax)));
        if ($urandom_range(0, 1)) ay = -ay;
        rad = 2040.0 + 785.0 * $urandom_range(0, 1000) / 1000.0;
        az = int'($sqrt(rad * rad - real'(ax * ax)));
        if ($urandom_range(0, 1)) az = -az;
        s.accel_x = 15'(ax - chk.reg_val[REG_ACCEL_X_OFFSET]);
        s.accel_y = 15'(ay - chk.reg_val[REG_ACCEL_Y_OFFSET]);
        s.accel_z = 15'(az - chk.reg_val[REG_ACCEL_Z_OFFSET]);
        if ($urandom_range(0, 9) == 0) begin
            s.rate_y = 16'($urandom);
            s.rate_z = 16'($urandom);
        end
        else begin
            s.rate_y = 16'(int'($urandom_range(0, 1200)) - 600);
            s.rate_z = 16'(int'($urandom_range(0, 1200)) - 600);
        end
        s.elapsed_ms = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(10, 40));
        if ($urandom_range(0, 4) == 0) btn_level = ~btn_level;
        s.button_pressed = btn_level;
        return s;
    endfunction

    task automatic push_sample(input sample_t s);
        sample_bus.valid <= 1'b1;
        sample_bus.accel_x <= s.accel_x;
        sample_bus.accel_y <= s.accel_y;
        sample_bus.accel_z <= s.accel_z;
        sample_bus.rate_y <= s.rate_y;
        sample_bus.rate_z <= s.rate_z;
        sample_bus.button_pressed <= s.button_pressed;
        sample_bus.elapsed_ms <= s.elapsed_ms;
        @(posedge clk);
        while (!sample_bus.ready) @(posedge clk);
        chk.take_sample(s);
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            sample_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        chk.set_reg(idx, val);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input int ox, input int oy, input int oz, input int ogy,
                                  input int ogz, input int tx, input int ty);
        write_reg(REG_ACCEL_X_OFFSET, 32'(ox));
        write_reg(REG_ACCEL_Y_OFFSET, 32'(oy));
        write_reg(REG_ACCEL_Z_OFFSET, 32'(oz));
        write_reg(REG_RATE_Y_OFFSET, 32'(ogy));
        write_reg(REG_RATE_Z_OFFSET, 32'(ogz));
        write_reg(REG_TRIM_X, 32'(tx));
        write_reg(REG_TRIM_Y, 32'(ty));
    endtask

    // stops the samples, waits until every predicted beat is taken, then drains before the next write
    task automatic settle();
        sample_bus.valid <= 1'b0;
        while (chk.pending() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    initial begin
        chk = new();
        quiet = 1'b0;
        btn_level = 1'b0;
        gap_pct = 20;
        stall_pct = 20;
        rst_n = 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        sample_bus.valid <= 1'b0;
        sample_bus.accel_x <= '0;
        sample_bus.accel_y <= '0;
        sample_bus.accel_z <= '0;
        sample_bus.rate_y <= '0;
        sample_bus.rate_z <= '0;
        sample_bus.button_pressed <= 1'b0;
        sample_bus.elapsed_ms <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_settings(0, 0, 0, 0, 0, 0, 0);
        // seed with the zero vector, then gate edges and field extremes
        push_sample(mk(0, 0, 0, 0, 0, 0, 20));
        push_sample(mk(2048, 0, 0, 100, -100, 0, 20));
        push_sample(mk(2049, 0, 0, 0, 0, 0, 20));
        push_sample(mk(-2815, 10, -10, 5, 5, 0, 25));
        push_sample(mk(2816, 0, 0, 0, 0, 0, 20));
        push_sample(mk(0, 2500, 0, 0, 0, 0, 20));
        push_sample(mk(0, -2500, 2500, 0, 0, 0, 20));
        push_sample(mk(-1800, -1700, 1700, 0, 0, 1, 20));
        push_sample(mk(16383, -16384, 16383, 32767, -32768, 1, 1023));
        push_sample(mk(-16384, 16383, -16384, -32768, 32767, 0, 1000));
        push_sample(mk(1500, 2000, -2000, 300, -300, 0, 0));
        // large rate over long gaps drives the estimates into saturation
        push_sample(mk(0, 0, 0, 32767, 32767, 0, 1023));
        push_sample(mk(0, 0, 0, 32767, 32767, 0, 1023));
        push_sample(mk(0, 0, 0, 32767, 32767, 1, 1023));
        push_sample(mk(0, 0, 0, 32767, 32767, 0, 1023));

        settle();
        apply_settings(2560, 2560, 2560, 4096, 4096, 12868, 12868);
        write_reg(REG_NONE, 32'hffff_ffff);
        push_sample(mk(0, 0, 0, -32768, -32768, 0, 1023));
        push_sample(mk(0, 0, 0, -32768, -32768, 0, 1023));
        push_sample(mk(0, 0, 0, -32768, -32768, 0, 1023));
        push_sample(mk(-4000, -2560, -2560, -32768, -32768, 0, 1023));

        settle();
        apply_settings(-2560, -2560, -2560, -4096, -4096, -12868, -12868);
        push_sample(mk(0, 0, 0, 32767, 32767, 0, 1023));
        push_sample(mk(0, 0, 0, 32767, 32767, 0, 1023));
        push_sample(mk(0, 0, 0, 32767, 32767, 0, 1023));
        push_sample(mk(4000, 2560, 2560, 32767, 32767, 1, 1023));

        for (int ph = 0; ph < 8; ph++) begin
            settle();
            case (ph)
                1: apply_settings(0, 0, 0, 0, 0, 0, 0);
                2: apply_settings(2560, 2560, 2560, 4096, 4096, 12868, 12868);
                3: apply_settings(-2560, -2560, -2560, -4096, -4096, -12868, -12868);
                default: apply_settings(int'($urandom_range(0, 5120)) - 2560,
                                        int'($urandom_range(0, 5120)) - 2560,
                                        int'($urandom_range(0, 5120)) - 2560,
                                        int'($urandom_range(0, 8192)) - 4096,
                                        int'($urandom_range(0, 8192)) - 4096,
                                        int'($urandom_range(0, 25736)) - 12868,
                                        int'($urandom_range(0, 25736)) - 12868);
            endcase
            gap_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 15 : 40;
            stall_pct = (ph % 3 == 2) ? 0 : (ph % 3 == 0) ? 15 : 40;
            quiet = (ph == 7);
            repeat (210) push_sample(rand_sample());
        end

        settle();
        if (chk.mismatches == 0 && chk.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hdl/gtcf_pkg.sv
hdl/gtcf_ifs.sv
hdl/gtcf_cordic.sv
hdl/gated_tilt_complementary_filter.sv
test/tb_gated_tilt_complementary_filter.sv
